// ===== rtl/core/dctfi_pkg.sv =====
// ----------------------------------------------------------------------------
// dctfi_pkg
// Shared types, constants and the cosine basis function for the 8x8
// forward/inverse DCT block.
// ----------------------------------------------------------------------------
package dctfi_pkg;

   localparam int SAMPLE_W     = 8;
   localparam int COEF_W       = 12;
   localparam int RECON_W      = 10;
   localparam int POS_W        = 6;
   localparam int TABLE_BITS   = 30;
   localparam int COEF_MIN     = -1024;
   localparam int COEF_MAX     = 1024;
   localparam int RECON_MIN    = -16;
   localparam int RECON_MAX    = 271;
   localparam int RECON_OFFSET = 128;
   localparam logic [POS_W-1:0] LAST_POS = 6'd63;

   // cos(m*pi/16), m = 0..8, 30 fraction bits
   localparam longint COS_Q30 [9] = '{
      64'd1073741824, 64'd1053110176, 64'd992008094, 64'd892783698,
      64'd759250125, 64'd596538995, 64'd410903207, 64'd209476638, 64'd0
   };
   localparam longint INV_SQRT2_Q30 = 64'd759250125;

   typedef enum logic [1:0] {
      PASS_FROW = 2'd0,
      PASS_FCOL = 2'd1,
      PASS_IROW = 2'd2,
      PASS_ICOL = 2'd3
   } pass_type;

   typedef struct packed {
      logic                 vld;
      logic                 first;
      logic                 last;
      pass_type             pass;
      logic [POS_W-1:0]     idx;
   } mac_tag_type;

   // C(k) cos((2n+1) k pi / 16) with frac fraction bits, magnitude rounded half up
   function automatic logic [31:0] basis_val(input int k, input int n, input int frac);
      logic [63:0] mag;
      logic [63:0] r;
      int          m;
      int          sh;
      logic        neg;
      neg = 1'b0;
      sh  = TABLE_BITS - frac;
      m   = 0;
      if (k == 0) begin
         mag = 64'(INV_SQRT2_Q30);
      end else begin
         m = ((2 * n + 1) * k) & 31;
         if (m > 16) m = 32 - m;
         if (m > 8) begin
            m   = 16 - m;
            neg = 1'b1;
         end
         mag = 64'(COS_Q30[m]);
      end
      r = (mag + (64'd1 << (sh - 1))) >> sh;
      return neg ? 32'(-r) : 32'(r);
   endfunction

endpackage

// ===== rtl/core/dctfi_if.sv =====
// ----------------------------------------------------------------------------
// dctfi_if
// Valid/ready channels of the DCT block: sample input and result output.
// ----------------------------------------------------------------------------
interface dctfi_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface dctfi_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         position;
   logic signed [11:0] coefficient;
   logic signed [9:0]  reconstructed;
   logic               last;

   modport source (output valid, output position, output coefficient,
                   output reconstructed, output last, input ready);
   modport sink   (input valid, input position, input coefficient,
                   input reconstructed, input last, output ready);
endinterface

// ===== rtl/core/dctfi_mac.sv =====
// ----------------------------------------------------------------------------
// dctfi_mac
// Shared multiply-accumulate unit: registered product, then an accumulator
// that restarts on the first tap and reports the sum after the last tap.
// ----------------------------------------------------------------------------
module dctfi_mac import dctfi_pkg::*; #(
   parameter int AW = 28,
   parameter int BW = 16,
   parameter int ACCW = 46
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mac_tag_type            tag_in,
   input  logic signed [AW-1:0]   a_in,
   input  logic signed [BW-1:0]   b_in,
   output mac_tag_type            tag_out,
   output logic signed [ACCW-1:0] acc_out,
   output logic                   busy
);

   mac_tag_type                  tag2_ff;
   mac_tag_type                  tag3_ff;
   logic signed [AW+BW-1:0]      prod_ff;
   logic signed [ACCW-1:0]       acc_ff;
   logic signed [ACCW-1:0]       prod_ext;

   always_ff @(posedge clock) begin
      prod_ff <= a_in * b_in;
      if (reset) begin
         tag2_ff.vld <= 1'b0;
      end else begin
         tag2_ff <= tag_in;
      end
   end

   assign prod_ext = ACCW'(prod_ff);

   always_ff @(posedge clock) begin
      if (tag2_ff.vld) begin
         acc_ff <= tag2_ff.first ? prod_ext : acc_ff + prod_ext;
      end
      if (reset) begin
         tag3_ff.vld <= 1'b0;
      end else begin
         // report only once the last tap has been summed
         tag3_ff <= {tag2_ff.vld & tag2_ff.last, tag2_ff.first, tag2_ff.last,
                     tag2_ff.pass, tag2_ff.idx};
      end
   end

   assign tag_out = tag3_ff;
   assign acc_out = acc_ff;
   assign busy    = tag2_ff.vld | tag3_ff.vld;

endmodule

// ===== rtl/core/dct8x8_forward_inverse.sv =====
// ----------------------------------------------------------------------------
// dct8x8_forward_inverse
// 8x8 2-D DCT-II and inverse on one shared multiply-accumulate unit.
//
//   channel | dir | payload                                   | transfer
//   req_ch  | in  | sample                                    | valid & ready
//   rsp_ch  | out | position, coefficient, reconstructed, last| valid & ready
//
// One block: 64 samples are loaded, then four passes of 512 multiply-adds
// run on the single multiplier, each pass followed by a pipeline drain,
// then 64 results are read out. req_ch is ready only while loading.
// Synchronous reset clears control only; the stores need no clearing.
// A stall on rsp_ch holds the current result and pauses readout.
// ----------------------------------------------------------------------------
module dct8x8_forward_inverse import dctfi_pkg::*; #(
   parameter int COSINE_FRACTION_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   dctfi_req_if.sink   req_ch,
   dctfi_rsp_if.source rsp_ch
);

   localparam int F    = COSINE_FRACTION_BITS;
   localparam int BW   = F + 2;
   localparam int AW   = F + 14;
   localparam int TW   = AW;
   localparam int ACCW = 2 * F + 18;
   localparam int SH   = 2 * F + 2;
   localparam int QW   = ACCW - SH;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   pass_type                pass_ff, pass_in;
   logic [POS_W-1:0]        load_cnt_ff;
   logic [POS_W-1:0]        idx_ff;
   logic [2:0]              tap_ff;
   logic [POS_W:0]          emit_cnt_ff;

   logic signed [BW-1:0]    basis_tbl [64];
   logic [POS_W-1:0]        aaddr;
   logic [POS_W-1:0]        bidx;
   logic                    issue;
   logic                    req_xfer;
   logic                    advance;
   logic                    emit_rd;
   logic                    pipe_empty;

   logic signed [SAMPLE_W-1:0] sample_mem [64];
   logic signed [TW-1:0]       tmp_mem    [64];
   logic signed [COEF_W-1:0]   coef_mem   [64];
   logic signed [RECON_W-1:0]  recon_mem  [64];

   logic signed [SAMPLE_W-1:0] sample_rd_ff;
   logic signed [TW-1:0]       tmp_rd_ff;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic signed [RECON_W-1:0]  recon_rd_ff;
   logic [POS_W-1:0]           coef_raddr;

   mac_tag_type             s1_tag_ff, s1_tag_in;
   logic signed [BW-1:0]    s1_b_ff;
   logic signed [AW-1:0]    op_a;
   mac_tag_type             mac_tag;
   logic signed [ACCW-1:0]  mac_acc;
   logic                    mac_busy;

   logic                    rnd_neg;
   logic [ACCW-1:0]         rnd_mag;
   logic [ACCW-1:0]         rnd_sum;
   logic [QW-1:0]           rnd_q;
   logic signed [QW:0]      rnd_val;
   logic signed [QW+1:0]    rec_val;
   logic signed [COEF_W-1:0] wr_data_in;

   logic                    wr_vld_ff;
   pass_type                wr_pass_ff;
   logic [POS_W-1:0]        wr_idx_ff;
   logic signed [COEF_W-1:0] wr_data_ff;

   logic                    rsp_vld_ff;
   logic [POS_W-1:0]        rsp_pos_ff;

   // basis constants, folded at elaboration
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         basis_tbl[i] = BW'(basis_val(i / 8, i % 8, F));
      end
   end

   assign req_xfer   = req_ch.valid & req_ch.ready;
   assign issue      = (state_ff == ST_RUN);
   assign advance    = ~rsp_vld_ff | rsp_ch.ready;
   assign emit_rd    = (state_ff == ST_EMIT) & advance & ~emit_cnt_ff[POS_W];
   assign pipe_empty = ~s1_tag_ff.vld & ~mac_busy & ~wr_vld_ff;

   // operand addresses: output (row, col) = idx, tap m
   always_comb begin
      unique case (pass_ff)
         PASS_FROW: begin
            aaddr = {idx_ff[5:3], tap_ff};
            bidx  = {idx_ff[2:0], tap_ff};
         end
         PASS_FCOL: begin
            aaddr = {tap_ff, idx_ff[2:0]};
            bidx  = {idx_ff[5:3], tap_ff};
         end
         PASS_IROW: begin
            aaddr = {idx_ff[5:3], tap_ff};
            bidx  = {tap_ff, idx_ff[2:0]};
         end
         PASS_ICOL: begin
            aaddr = {tap_ff, idx_ff[2:0]};
            bidx  = {tap_ff, idx_ff[5:3]};
         end
         default: begin
            aaddr = '0;
            bidx  = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer && load_cnt_ff == LAST_POS) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (idx_ff == LAST_POS && tap_ff == 3'd7) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               if (pass_ff == PASS_ICOL) begin
                  state_in = ST_EMIT;
                  pass_in  = PASS_FROW;
               end else begin
                  state_in = ST_RUN;
                  unique case (pass_ff)
                     PASS_FROW: pass_in = PASS_FCOL;
                     PASS_FCOL: pass_in = PASS_IROW;
                     default:   pass_in = PASS_ICOL;
                  endcase
               end
            end
         end
         ST_EMIT: begin
            if (advance && emit_cnt_ff[POS_W]) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         pass_ff     <= PASS_FROW;
         load_cnt_ff <= '0;
         idx_ff      <= '0;
         tap_ff      <= '0;
         emit_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         if (req_xfer) load_cnt_ff <= load_cnt_ff + 1'b1;
         if (issue) begin
            tap_ff <= tap_ff + 1'b1;
            if (tap_ff == 3'd7) idx_ff <= idx_ff + 1'b1;
         end
         if (state_ff != ST_EMIT) begin
            emit_cnt_ff <= '0;
         end else if (emit_rd) begin
            emit_cnt_ff <= emit_cnt_ff + 1'b1;
         end
      end
   end

   // memories
   assign coef_raddr = (state_ff == ST_EMIT) ? emit_cnt_ff[POS_W-1:0] : aaddr;

   always_ff @(posedge clock) begin
      if (req_xfer) sample_mem[load_cnt_ff] <= req_ch.sample;
      sample_rd_ff <= sample_mem[aaddr];
   end

   always_ff @(posedge clock) begin
      if (mac_tag.vld && (mac_tag.pass == PASS_FROW || mac_tag.pass == PASS_IROW)) begin
         tmp_mem[mac_tag.idx] <= mac_acc[TW-1:0];
      end
      tmp_rd_ff <= tmp_mem[aaddr];
   end

   always_ff @(posedge clock) begin
      if (wr_vld_ff && wr_pass_ff == PASS_FCOL) coef_mem[wr_idx_ff] <= wr_data_ff;
      if (issue || emit_rd) coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_vld_ff && wr_pass_ff == PASS_ICOL) recon_mem[wr_idx_ff] <= wr_data_ff[RECON_W-1:0];
      if (emit_rd) recon_rd_ff <= recon_mem[emit_cnt_ff[POS_W-1:0]];
   end

   // operand stage
   always_comb begin
      s1_tag_in.vld   = issue;
      s1_tag_in.first = (tap_ff == 3'd0);
      s1_tag_in.last  = (tap_ff == 3'd7);
      s1_tag_in.pass  = pass_ff;
      s1_tag_in.idx   = idx_ff;
   end

   always_ff @(posedge clock) begin
      s1_b_ff <= basis_tbl[bidx];
      if (reset) begin
         s1_tag_ff.vld <= 1'b0;
      end else begin
         s1_tag_ff <= s1_tag_in;
      end
   end

   always_comb begin
      case (s1_tag_ff.pass)
         PASS_FROW: op_a = {{(AW-SAMPLE_W){sample_rd_ff[SAMPLE_W-1]}}, sample_rd_ff};
         PASS_IROW: op_a = {{(AW-COEF_W){coef_rd_ff[COEF_W-1]}}, coef_rd_ff};
         default:   op_a = tmp_rd_ff;
      endcase
   end

   dctfi_mac #(
      .AW   (AW),
      .BW   (BW),
      .ACCW (ACCW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (s1_tag_ff),
      .a_in    (op_a),
      .b_in    (s1_b_ff),
      .tag_out (mac_tag),
      .acc_out (mac_acc),
      .busy    (mac_busy)
   );

   // round half away from zero, then saturate
   always_comb begin
      rnd_neg = mac_acc[ACCW-1];
      rnd_mag = rnd_neg ? (~mac_acc + 1'b1) : mac_acc;
      rnd_sum = rnd_mag + (ACCW'(1) << (SH - 1));
      rnd_q   = rnd_sum[ACCW-1:SH];
      rnd_val = rnd_neg ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
      rec_val = (QW+2)'(rnd_val) + (QW+2)'(RECON_OFFSET);
      if (mac_tag.pass == PASS_FCOL) begin
         if (rnd_val < $signed((QW+1)'(COEF_MIN))) begin
            wr_data_in = COEF_W'(COEF_MIN);
         end else if (rnd_val > $signed((QW+1)'(COEF_MAX))) begin
            wr_data_in = COEF_W'(COEF_MAX);
         end else begin
            wr_data_in = rnd_val[COEF_W-1:0];
         end
      end else begin
         if (rec_val < $signed((QW+2)'(RECON_MIN))) begin
            wr_data_in = COEF_W'(RECON_MIN);
         end else if (rec_val > $signed((QW+2)'(RECON_MAX))) begin
            wr_data_in = COEF_W'(RECON_MAX);
         end else begin
            wr_data_in = rec_val[COEF_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_pass_ff <= mac_tag.pass;
      wr_idx_ff  <= mac_tag.idx;
      wr_data_ff <= wr_data_in;
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= mac_tag.vld &
                      (mac_tag.pass == PASS_FCOL || mac_tag.pass == PASS_ICOL);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit_rd) rsp_pos_ff <= emit_cnt_ff[POS_W-1:0];
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= emit_rd;
      end
   end

   assign req_ch.ready         = (state_ff == ST_LOAD);
   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.position      = rsp_pos_ff;
   assign rsp_ch.coefficient   = coef_rd_ff;
   assign rsp_ch.reconstructed = recon_rd_ff;
   assign rsp_ch.last          = (rsp_pos_ff == LAST_POS);

   a_no_rsp_while_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_DRAIN) |-> !rsp_vld_ff)
      else $error("result shown while computing");

   a_full_block_starts: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && load_cnt_ff == LAST_POS) |=> (state_ff == ST_RUN && pass_ff == PASS_FROW))
      else $error("block did not start after 64th sample");

   a_drained_before_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_EMIT) |-> (pipe_empty && emit_cnt_ff == '0))
      else $error("readout started with work in flight");

   a_pass_boundary_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && idx_ff == '0 && tap_ff == '0) |-> !wr_vld_ff && !mac_busy)
      else $error("pass began before previous pass drained");

endmodule

// ===== bench/dct8x8_forward_inverse_test.sv =====
// ----------------------------------------------------------------------------
// dct8x8_forward_inverse_test
// Feeds 8x8 blocks of signed samples into the forward/inverse DCT and checks
// every coefficient and reconstructed pixel against a fixed-point transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dct8x8_forward_inverse_test;
   import dctfi_pkg::*;

   localparam int FRAC       = 14;
   localparam int BLOCK_LEN  = 64;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [5:0]         position;
      logic signed [11:0] coefficient;
      logic signed [9:0]  reconstructed;
      logic               last;
   } pixel_result_type;

   logic clock;
   logic reset;

   dctfi_req_if req_ch ();
   dctfi_rsp_if rsp_ch ();

   dct8x8_forward_inverse #(.COSINE_FRACTION_BITS(FRAC)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   logic signed [7:0] sample_queue[$];
   pixel_result_type  expected_pixels[$];
   longint            block_samples[64];
   int                fill_count;
   longint            basis_tab[8][8];
   int                mismatches;
   int                idle_cycles;
   bit                calm_phase;
   bit                hold_rsp;
   int                send_gap;
   int                recv_gap;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint to_frac(longint mag30, bit neg);
      longint r;
      r = (mag30 + (longint'(1) << (TABLE_BITS - FRAC - 1))) >>> (TABLE_BITS - FRAC);
      return neg ? -r : r;
   endfunction

   function automatic longint cos_basis(int k, int n);
      int m;
      bit neg;
      neg = 0;
      if (k == 0) return to_frac(759250125, 0);
      m = ((2 * n + 1) * k) & 31;
      if (m > 16) m = 32 - m;
      if (m > 8) begin
         m = 16 - m;
         neg = 1;
      end
      case (m)
         0: return to_frac(1073741824, neg);
         1: return to_frac(1053110176, neg);
         2: return to_frac(992008094, neg);
         3: return to_frac(892783698, neg);
         4: return to_frac(759250125, neg);
         5: return to_frac(596538995, neg);
         6: return to_frac(410903207, neg);
         7: return to_frac(209476638, neg);
         default: return 0;
      endcase
   endfunction

   // remove 2F+2 fraction bits, half away from zero
   function automatic longint descale(longint acc);
      longint mag;
      longint q;
      int sh;
      sh  = 2 * FRAC + 2;
      mag = acc < 0 ? -acc : acc;
      q   = (mag + (longint'(1) << (sh - 1))) >>> sh;
      return acc < 0 ? -q : q;
   endfunction

   function automatic longint saturate(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic transform_block();
      longint tmp[8][8];
      longint coef[64];
      longint acc;
      longint rec;
      pixel_result_type px;
      for (int i = 0; i < 8; i++)
         for (int k = 0; k < 8; k++) begin
            acc = 0;
            for (int j = 0; j < 8; j++) acc += block_samples[i*8+j] * basis_tab[k][j];
            tmp[i][k] = acc;
         end
      for (int i = 0; i < 8; i++)
         for (int k = 0; k < 8; k++) begin
            acc = 0;
            for (int j = 0; j < 8; j++) acc += tmp[j][k] * basis_tab[i][j];
            coef[i*8+k] = saturate(descale(acc), COEF_MIN, COEF_MAX);
         end
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 8; j++) begin
            acc = 0;
            for (int k = 0; k < 8; k++) acc += coef[i*8+k] * basis_tab[k][j];
            tmp[i][j] = acc;
         end
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 8; j++) begin
            acc = 0;
            for (int k = 0; k < 8; k++) acc += tmp[k][j] * basis_tab[k][i];
            rec = saturate(descale(acc) + RECON_OFFSET, RECON_MIN, RECON_MAX);
            px.position      = 6'(i*8+j);
            px.coefficient   = 12'(coef[i*8+j]);
            px.reconstructed = 10'(rec);
            px.last          = (px.position == LAST_POS);
            expected_pixels.push_back(px);
         end
   endtask

   // sample accepted: store and, on the 64th, predict the block
   task automatic take_sample(logic signed [7:0] s);
      block_samples[fill_count] = s;
      fill_count++;
      if (fill_count == BLOCK_LEN) begin
         fill_count = 0;
         transform_block();
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.sample <= '0;
         send_gap      <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            take_sample(req_ch.sample);
            void'(sample_queue.pop_front());
         end
         if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 19) == 0 &&
                      !(req_ch.valid && !req_ch.ready)) begin
            send_gap     <= $urandom_range(1, 10) - 1;
            req_ch.valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_ch.valid  <= 1'b1;
            req_ch.sample <= sample_queue[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      pixel_result_type exp_px;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
         idle_cycles  <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result at position %0d", rsp_ch.position);
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_ch.position !== exp_px.position ||
                   rsp_ch.coefficient !== exp_px.coefficient ||
                   rsp_ch.reconstructed !== exp_px.reconstructed ||
                   rsp_ch.last !== exp_px.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                        exp_px.position, exp_px.coefficient, exp_px.reconstructed,
                        exp_px.last, rsp_ch.position, rsp_ch.coefficient,
                        rsp_ch.reconstructed, rsp_ch.last);
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap     <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            recv_gap     <= $urandom_range(1, 10) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic queue_block(int kind);
      for (int p = 0; p < BLOCK_LEN; p++)
         case (kind)
            0: sample_queue.push_back(8'sd127);
            1: sample_queue.push_back(-8'sd128);
            2: sample_queue.push_back((((p >> 3) + p) & 1) ? 8'sd127 : -8'sd128);
            default: sample_queue.push_back(8'($urandom_range(0, 255)));
         endcase
   endtask

   task automatic wait_drained();
      while (sample_queue.size() > 0 || expected_pixels.size() > 0) @(posedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      calm_phase   = 1'b0;
      hold_rsp     = 1'b0;
      fill_count   = 0;
      mismatches   = 0;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      for (int k = 0; k < 8; k++)
         for (int n = 0; n < 8; n++) basis_tab[k][n] = cos_basis(k, n);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full-scale checkerboard, then a partial block offered while the
      // receiver holds off
      hold_rsp = 1'b1;
      queue_block(2);
      for (int p = 0; p < 20; p++) sample_queue.push_back(8'($urandom_range(0, 255)));
      repeat (4000) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      // complete the partial block with no idling
      calm_phase = 1'b1;
      for (int p = 20; p < BLOCK_LEN; p++) sample_queue.push_back(8'($urandom_range(0, 255)));
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/dctfi_pkg.sv
rtl/core/dctfi_if.sv
rtl/core/dctfi_mac.sv
rtl/core/dct8x8_forward_inverse.sv
bench/dct8x8_forward_inverse_test.sv
